>>> rtl/sfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants for the streaming find-and-replace block: string limits,
// the newline code and the configuration register indexes.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int MAX_STRING_LEN_DEF = 8;

    localparam int BYTE_W     = 8;
    localparam int STR_W      = 64;
    localparam int LEN_W      = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_BYTES  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEN    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_BYTES = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LEN   = 4'd3;

endpackage

>>> rtl/stream_find_replace_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_replace_top
// Streaming find-and-replace over a byte stream, one byte per input beat.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one text byte per beat, or an end-of-input beat that flushes
//   the pending bytes and closes an open line with a newline.
//   m_* channel: one output byte per beat; m_last_of_run marks the final byte
//   that one input beat produced. An input beat may produce no output beat.
//   cfg_* channel: writes target/replacement strings and lengths; write only
//   while the block is idle. cfg_ready is always high.
// Sequencing:
//   One input beat at a time. The sequencer takes the beat; for a text byte
//   it runs the scan loop (one prefix check, plus one per byte dropped as a
//   literal) and emits any replacement bytes; for a newline or end of input
//   it emits the flushed bytes; each beat ends in a closing state. Stalls
//   hold the sequencer. A single compare unit checks the pending buffer.
//   Output leaves through a one-byte hold stage and an output register: an
//   emitted byte waits in the hold stage until the next emitted byte or the
//   closing state moves it to the output register.
// Reset: pending buffer empty, line closed, target and replacement of length
//   one holding byte zero. When the receiver stalls, the sequencer holds at
//   the next byte it needs to emit; s_ready stays low until the beat is done.
// ----------------------------------------------------------------------------
module stream_find_replace_top #(
    parameter int MAX_STRING_LEN = sfr_pkg::MAX_STRING_LEN_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [sfr_pkg::BYTE_W-1:0]       s_data_byte,
    input  logic                             s_end_of_input,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [sfr_pkg::BYTE_W-1:0]       m_out_byte,
    output logic                             m_last_of_run,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CNT_W = $clog2(MAX_STRING_LEN + 1);
    localparam int IDX_W = (MAX_STRING_LEN > 1) ? $clog2(MAX_STRING_LEN) : 1;
    localparam int BW    = sfr_pkg::BYTE_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_REPL  = 3'd2;
    localparam logic [2:0] ST_FLUSH = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    // configuration
    logic [sfr_pkg::STR_W-1:0] target_bytes_reg;
    logic [sfr_pkg::LEN_W-1:0] target_len_reg;
    logic [sfr_pkg::STR_W-1:0] replace_bytes_reg;
    logic [sfr_pkg::LEN_W-1:0] replace_len_reg;

    // sequencer and stream state
    logic [2:0]        state_reg,     state_next;
    logic [CNT_W-1:0]  cnt_reg,       cnt_next;
    logic [IDX_W-1:0]  rep_idx_reg,   rep_idx_next;
    logic              line_open_reg, line_open_next;
    logic              is_nl_reg,     is_nl_next;
    logic [BW-1:0]     buf_reg [MAX_STRING_LEN];

    // hold stage and output register
    logic              hold_valid_reg, hold_valid_next;
    logic [BW-1:0]     hold_byte_reg,  hold_byte_next;
    logic              out_valid_reg,  out_valid_next;
    logic [BW-1:0]     out_byte_reg,   out_byte_next;
    logic              out_last_reg,   out_last_next;

    logic [CNT_W-1:0]  tlen;
    logic [CNT_W-1:0]  rlen;
    logic              match_ok;
    logic              slot_free;
    logic              emit_ok;
    logic              emit;
    logic [BW-1:0]     emit_byte;
    logic              shift;
    logic              load;

    assign cfg_ready     = 1'b1;
    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = out_valid_reg;
    assign m_out_byte    = out_byte_reg;
    assign m_last_of_run = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_bytes_reg  <= '0;
            target_len_reg    <= sfr_pkg::LEN_W'(1);
            replace_bytes_reg <= '0;
            replace_len_reg   <= sfr_pkg::LEN_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                sfr_pkg::REG_TARGET_BYTES:  target_bytes_reg  <= cfg_data;
                sfr_pkg::REG_TARGET_LEN:    target_len_reg    <= cfg_data[sfr_pkg::LEN_W-1:0];
                sfr_pkg::REG_REPLACE_BYTES: replace_bytes_reg <= cfg_data;
                sfr_pkg::REG_REPLACE_LEN:   replace_len_reg   <= cfg_data[sfr_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp lengths into 1..MAX_STRING_LEN
    always_comb begin
        if (target_len_reg == '0) begin
            tlen = CNT_W'(1);
        end else if (target_len_reg > sfr_pkg::LEN_W'(MAX_STRING_LEN)) begin
            tlen = CNT_W'(MAX_STRING_LEN);
        end else begin
            tlen = CNT_W'(target_len_reg);
        end
        if (replace_len_reg == '0) begin
            rlen = CNT_W'(1);
        end else if (replace_len_reg > sfr_pkg::LEN_W'(MAX_STRING_LEN)) begin
            rlen = CNT_W'(MAX_STRING_LEN);
        end else begin
            rlen = CNT_W'(replace_len_reg);
        end
    end

    // prefix check: the buffered bytes must be the start of the target
    always_comb begin
        match_ok = (cnt_reg <= tlen);
        for (int i = 0; i < MAX_STRING_LEN; i++) begin
            if ((CNT_W'(i) < cnt_reg) && (buf_reg[i] != target_bytes_reg[i*BW +: BW])) begin
                match_ok = 1'b0;
            end
        end
    end

    assign slot_free = !out_valid_reg || m_ready;
    assign emit_ok   = !hold_valid_reg || slot_free;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rep_idx_next   = rep_idx_reg;
        line_open_next = line_open_reg;
        is_nl_next     = is_nl_reg;
        hold_valid_next = hold_valid_reg;
        hold_byte_next = hold_byte_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        emit           = 1'b0;
        emit_byte      = '0;
        shift          = 1'b0;
        load           = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_end_of_input) begin
                        is_nl_next = 1'b0;
                        state_next = ST_FLUSH;
                    end else if (s_data_byte == sfr_pkg::NEWLINE_BYTE) begin
                        is_nl_next = 1'b1;
                        state_next = ST_FLUSH;
                    end else begin
                        load           = 1'b1;
                        cnt_next       = cnt_reg + CNT_W'(1);
                        line_open_next = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (!match_ok) begin
                    // drop the oldest byte as a literal and check again
                    if (emit_ok) begin
                        emit      = 1'b1;
                        emit_byte = buf_reg[0];
                        shift     = 1'b1;
                        cnt_next  = cnt_reg - CNT_W'(1);
                    end
                end else if (cnt_reg == tlen) begin
                    cnt_next     = '0;
                    rep_idx_next = '0;
                    state_next   = ST_REPL;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_REPL: begin
                if (emit_ok) begin
                    emit      = 1'b1;
                    emit_byte = replace_bytes_reg[{rep_idx_reg, 3'b000} +: BW];
                    if (CNT_W'(rep_idx_reg) == rlen - CNT_W'(1)) begin
                        state_next = ST_DONE;
                    end else begin
                        rep_idx_next = rep_idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (cnt_reg != '0) begin
                    if (emit_ok) begin
                        emit      = 1'b1;
                        emit_byte = buf_reg[0];
                        shift     = 1'b1;
                        cnt_next  = cnt_reg - CNT_W'(1);
                    end
                end else if (is_nl_reg || line_open_reg) begin
                    if (emit_ok) begin
                        emit           = 1'b1;
                        emit_byte      = sfr_pkg::NEWLINE_BYTE;
                        line_open_next = 1'b0;
                        state_next     = ST_DONE;
                    end
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // release the held byte as the last of this run
                if (!hold_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (slot_free) begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = hold_byte_reg;
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // a new byte pushes the held one out, not last
        if (emit) begin
            if (hold_valid_reg) begin
                out_valid_next = 1'b1;
                out_byte_next  = hold_byte_reg;
                out_last_next  = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_byte_next  = emit_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            rep_idx_reg    <= '0;
            line_open_reg  <= 1'b0;
            is_nl_reg      <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rep_idx_reg    <= rep_idx_next;
            line_open_reg  <= line_open_next;
            is_nl_reg      <= is_nl_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_byte_reg <= hold_byte_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
    end

    // pending buffer, oldest byte at entry 0
    always_ff @(posedge aclk) begin
        if (load) begin
            buf_reg[cnt_reg[IDX_W-1:0]] <= s_data_byte;
        end else if (shift) begin
            for (int i = 0; i < MAX_STRING_LEN - 1; i++) begin
                buf_reg[i] <= buf_reg[i+1];
            end
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_STRING_LEN))
        else $error("pending count above buffer depth");

    a_idle_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (cnt_reg < CNT_W'(MAX_STRING_LEN)))
        else $error("no room for a new byte while idle");

    a_idle_no_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !hold_valid_reg)
        else $error("held byte left behind at end of run");

    a_rep_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REPL) |-> (CNT_W'(rep_idx_reg) < rlen))
        else $error("replacement index past length");

    a_out_from_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(hold_valid_reg))
        else $error("output beat without a held byte");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stream_find_replace_top. A directed run covers the
// reset strings, the longest output burst, newline and end-of-input flushes,
// out-of-range lengths and a target change with bytes still held. Random
// phases follow, each with its own strings, feeding text built around the
// target. Every output beat is checked against a software copy of the block.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 48;
    localparam int LONG_STALL   = 300;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 55;

    typedef struct packed {
        logic [sfr_pkg::BYTE_W-1:0] data;
        logic                       eoi;
    } in_beat_t;

    typedef struct packed {
        logic [sfr_pkg::BYTE_W-1:0] ob;
        logic                       last;
    } out_beat_t;

    typedef enum {RX_FULL, RX_COIN, RX_PULSE} rx_mode_t;

    logic                           aclk;
    logic                           aresetn        = 1'b0;
    logic                           s_valid        = 1'b0;
    logic                           s_ready;
    logic [sfr_pkg::BYTE_W-1:0]     s_data_byte    = '0;
    logic                           s_end_of_input = 1'b0;
    logic                           m_valid;
    logic                           m_ready        = 1'b0;
    logic [sfr_pkg::BYTE_W-1:0]     m_out_byte;
    logic                           m_last_of_run;
    logic                           cfg_valid      = 1'b0;
    logic                           cfg_ready;
    logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index      = sfr_pkg::REG_TARGET_BYTES;
    logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data       = '0;

    // software copy of the block: strings, held bytes, line state
    logic [sfr_pkg::STR_W-1:0]  tgt_str  = '0;
    logic [sfr_pkg::LEN_W-1:0]  tgt_lenr = 4'd1;
    logic [sfr_pkg::STR_W-1:0]  rep_str  = '0;
    logic [sfr_pkg::LEN_W-1:0]  rep_lenr = 4'd1;
    logic [sfr_pkg::BYTE_W-1:0] held_bytes [8];
    int                         held_n    = 0;
    bit                         line_busy = 1'b0;

    in_beat_t  text_in_q [$];
    out_beat_t out_text_q [$];
    int        n_queued = 0;
    int        n_taken  = 0;
    int        n_fail   = 0;
    int        cycle_cnt = 0;

    int        tx_burst_left = 0;
    int        tx_gap_left   = 0;
    in_beat_t  tx_next;

    rx_mode_t  rx_mode       = RX_FULL;
    int        rx_mode_left  = 0;
    int        rx_phase      = 0;
    int        rx_hold_left  = 0;
    int        long_stall_req  = 0;
    int        long_stall_seen = 0;
    out_beat_t exp_beat;

    stream_find_replace_top u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_end_of_input (s_end_of_input),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_last_of_run  (m_last_of_run),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int eff_len(input logic [sfr_pkg::LEN_W-1:0] v);
        if (v == 0) return 1;
        if (v > sfr_pkg::MAX_STRING_LEN_DEF) return sfr_pkg::MAX_STRING_LEN_DEF;
        return int'(v);
    endfunction

    function automatic void push_out(input logic [sfr_pkg::BYTE_W-1:0] v);
        out_beat_t e;
        e.ob   = v;
        e.last = 1'b0;
        out_text_q.push_back(e);
    endfunction

    // expected output beats for one accepted input beat
    function automatic void find_replace_step(input logic [sfr_pkg::BYTE_W-1:0] b,
                                              input logic eoi);
        logic [sfr_pkg::BYTE_W-1:0] win [8];
        int                         cnt, tl, rl, n0, i;
        bit                         ok;
        out_beat_t                  tail;
        n0 = out_text_q.size();
        if (eoi || b == sfr_pkg::NEWLINE_BYTE) begin
            for (i = 0; i < held_n; i++)
                push_out(held_bytes[i]);
            held_n = 0;
            if (!eoi || line_busy)
                push_out(sfr_pkg::NEWLINE_BYTE);
            line_busy = 1'b0;
        end else begin
            tl  = eff_len(tgt_lenr);
            rl  = eff_len(rep_lenr);
            win = held_bytes;
            cnt = (held_n > 7) ? 7 : held_n;
            win[cnt] = b;
            cnt++;
            line_busy = 1'b1;
            // drop the oldest byte until the window is a prefix of the target
            ok = 1'b0;
            while (!ok) begin
                ok = (cnt <= tl);
                for (i = 0; ok && i < cnt; i++)
                    if (win[i] != tgt_str[i*8 +: 8])
                        ok = 1'b0;
                if (!ok) begin
                    push_out(win[0]);
                    for (i = 0; i < 7; i++)
                        win[i] = win[i+1];
                    cnt--;
                end
            end
            if (cnt == tl) begin
                for (i = 0; i < rl; i++)
                    push_out(rep_str[i*8 +: 8]);
                cnt = 0;
            end
            held_bytes = win;
            held_n     = cnt;
        end
        if (out_text_q.size() > n0) begin
            tail      = out_text_q.pop_back();
            tail.last = 1'b1;
            out_text_q.push_back(tail);
        end
    endfunction

    function automatic void push_item(input logic [sfr_pkg::BYTE_W-1:0] d, input logic e);
        in_beat_t it;
        it.data = d;
        it.eoi  = e;
        text_in_q.push_back(it);
        n_queued++;
    endfunction

    task automatic cfg_write(input logic [sfr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sfr_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            sfr_pkg::REG_TARGET_BYTES:  tgt_str  = val;
            sfr_pkg::REG_TARGET_LEN:    tgt_lenr = val[sfr_pkg::LEN_W-1:0];
            sfr_pkg::REG_REPLACE_BYTES: rep_str  = val;
            sfr_pkg::REG_REPLACE_LEN:   rep_lenr = val[sfr_pkg::LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_strings(input logic [sfr_pkg::STR_W-1:0] ts,
                               input logic [sfr_pkg::LEN_W-1:0] tl,
                               input logic [sfr_pkg::STR_W-1:0] rs,
                               input logic [sfr_pkg::LEN_W-1:0] rl);
        cfg_write(sfr_pkg::REG_TARGET_BYTES, ts);
        cfg_write(sfr_pkg::REG_TARGET_LEN, sfr_pkg::CFG_DATA_W'(tl));
        cfg_write(sfr_pkg::REG_REPLACE_BYTES, rs);
        cfg_write(sfr_pkg::REG_REPLACE_LEN, sfr_pkg::CFG_DATA_W'(rl));
        cfg_valid <= 1'b0;
    endtask

    // hold until every beat is taken and answered, then let a silent beat finish
    task automatic wait_drained();
        while (n_taken != n_queued || out_text_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                find_replace_step(s_data_byte, s_end_of_input);
                n_taken++;
            end
            if (!s_valid || s_ready) begin
                if (tx_gap_left > 0) begin
                    tx_gap_left--;
                    s_valid <= 1'b0;
                end else if (text_in_q.size() != 0) begin
                    tx_next = text_in_q.pop_front();
                    s_valid        <= 1'b1;
                    s_data_byte    <= tx_next.data;
                    s_end_of_input <= tx_next.eoi;
                    if (tx_burst_left > 0) begin
                        tx_burst_left--;
                    end else begin
                        tx_burst_left = $urandom_range(0, 24);
                        tx_gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each beat, stall on a pattern of its own
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (out_text_q.size() == 0) begin
                    $error("unexpected output beat: out_byte %02h last_of_run %0b",
                           m_out_byte, m_last_of_run);
                    n_fail++;
                end else begin
                    exp_beat = out_text_q.pop_front();
                    if (m_out_byte !== exp_beat.ob) begin
                        $error("out_byte: expected %02h, got %02h", exp_beat.ob, m_out_byte);
                        n_fail++;
                    end
                    if (m_last_of_run !== exp_beat.last) begin
                        $error("last_of_run: expected %0b, got %0b", exp_beat.last, m_last_of_run);
                        n_fail++;
                    end
                end
            end
            if (long_stall_seen != long_stall_req) begin
                long_stall_seen = long_stall_req;
                rx_hold_left    = LONG_STALL;
            end
            if (rx_mode_left == 0) begin
                rx_mode      = rx_mode_t'($urandom_range(0, 2));
                rx_mode_left = $urandom_range(30, 150);
            end else begin
                rx_mode_left--;
            end
            rx_phase++;
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_FULL: m_ready <= 1'b1;
                    RX_COIN: m_ready <= ($urandom_range(0, 1) == 1);
                    default: m_ready <= ((rx_phase % 5) >= 2);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        logic [sfr_pkg::STR_W-1:0] ts, rs;
        logic [sfr_pkg::LEN_W-1:0] tlr, rlr;
        logic [sfr_pkg::BYTE_W-1:0] base;
        int p, n, i, k, tl, pick;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset strings: byte zero replaced by byte zero
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(sfr_pkg::NEWLINE_BYTE, 1'b0);
        push_item(8'hFF, 1'b1);
        push_item(8'h41, 1'b0);
        push_item(8'h00, 1'b1);
        wait_drained();

        set_strings(64'h6867_6665_6463_6261, 4'd8, '1, 4'd8);
        for (i = 0; i < 8; i++)
            push_item(sfr_pkg::BYTE_W'(8'h61 + i), 1'b0);
        push_item(8'h61, 1'b0);
        push_item(sfr_pkg::NEWLINE_BYTE, 1'b0);
        for (i = 0; i < 7; i++)
            push_item(sfr_pkg::BYTE_W'(8'h61 + i), 1'b0);
        wait_drained();

        // seven bytes held; one-byte target (length zero) forces the longest burst
        set_strings(64'h68, 4'd0, '1, 4'd15);
        push_item(8'h68, 1'b0);
        push_item(8'h00, 1'b1);
        wait_drained();

        for (p = 0; p < PHASES; p++) begin
            base = sfr_pkg::BYTE_W'($urandom_range(0, 255));
            for (i = 0; i < 8; i++)
                ts[i*8 +: 8] = sfr_pkg::BYTE_W'(base + $urandom_range(0, 2));
            rs = {$urandom, $urandom};
            case (p)
                0: begin tlr = 4'd3;  rlr = 4'd1; end
                1: begin tlr = 4'd8;  rlr = 4'd8; end
                2: begin ts = {$urandom, $urandom}; tlr = 4'd2; rs = '0; rlr = 4'd0; end
                3: begin ts = '1; tlr = 4'd9; rs = '1; rlr = 4'd15; end
                4: begin ts = '0; tlr = 4'd1; rlr = 4'd5; end
                5: begin tlr = 4'd15; rlr = 4'd3; end
                6: begin tlr = 4'd4;  rlr = 4'd8; end
                default: begin
                    tlr = sfr_pkg::LEN_W'($urandom_range(1, 8));
                    rlr = sfr_pkg::LEN_W'($urandom_range(0, 15));
                end
            endcase
            set_strings(ts, tlr, rs, rlr);
            if (p == 2)
                long_stall_req++;
            tl = eff_len(tgt_lenr);
            n  = 0;
            while (n < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    for (i = 0; i < tl; i++)
                        push_item(tgt_str[i*8 +: 8], 1'b0);
                    n += tl;
                end else if (pick < 50) begin
                    // partial match broken by another target byte
                    k = $urandom_range(1, tl);
                    for (i = 0; i < k; i++)
                        push_item(tgt_str[i*8 +: 8], 1'b0);
                    push_item(tgt_str[$urandom_range(0, tl - 1)*8 +: 8], 1'b0);
                    n += k + 1;
                end else if (pick < 70) begin
                    push_item(tgt_str[$urandom_range(0, tl - 1)*8 +: 8], 1'b0);
                    n++;
                end else if (pick < 84) begin
                    push_item(sfr_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0);
                    n++;
                end else if (pick < 94) begin
                    push_item(sfr_pkg::NEWLINE_BYTE, 1'b0);
                    n++;
                end else begin
                    push_item(sfr_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1);
                    n++;
                end
            end
            wait_drained();
        end

        if (n_fail == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> stream_find_replace_top.f
rtl/sfr_pkg.sv
rtl/stream_find_replace_top.sv
tb/tb.sv
